// ===== sv/csp_pkg.sv =====
// Package with the shared constants, types and helper function of the callsign parser.
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

    localparam int MAX_BASE_CHARS_DEF = 9;
    localparam int BASE_LIMIT         = 6;
    localparam int SSID_LIMIT         = 15;
    localparam int CASE_OFFSET        = 32;
    localparam int SSID_DIGITS        = 2;
    localparam int VALUE_SAT          = 127;
    localparam int CALL_W             = 8 * BASE_LIMIT;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_LOWZ  = 8'h7A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef logic [7:0] t_char;

    typedef struct packed {
        logic              valid_res;
        logic [CALL_W-1:0] base_call;
        logic [2:0]        base_length;
        logic              ssid_present;
        logic [3:0]        ssid_value;
    } t_result;

    // Decimal accumulate of one digit, saturating at VALUE_SAT.
    function automatic logic [6:0] sat_decimal(input logic [6:0] acc, input logic [3:0] dig);
        logic [10:0] v;
        v = 11'(acc) * 11'd10 + 11'(dig);
        if (v > 11'(VALUE_SAT)) begin
            return 7'(VALUE_SAT);
        end
        return v[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/csp_in_if.sv =====
// Character channel of the callsign parser.
`timescale 1ns / 1ps
`default_nettype none

interface csp_in_if;
    import csp_pkg::*;

    logic  valid;
    logic  ready;
    t_char character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/csp_out_if.sv =====
// Result channel of the callsign parser.
`timescale 1ns / 1ps
`default_nettype none

interface csp_out_if;
    import csp_pkg::*;

    logic              valid;
    logic              ready;
    logic              valid_res;
    logic [CALL_W-1:0] base_call;
    logic [2:0]        base_length;
    logic              ssid_present;
    logic [3:0]        ssid_value;

    modport source (output valid, output valid_res, output base_call, output base_length,
                    output ssid_present, output ssid_value, input ready);
    modport sink   (input valid, input valid_res, input base_call, input base_length,
                    input ssid_present, input ssid_value, output ready);
endinterface

`default_nettype wire

// ===== sv/csp_state.sv =====
// Parse state of the callsign parser and the result formed on the final character.
`timescale 1ns / 1ps
`default_nettype none

module csp_state #(
    parameter int MAX_BASE_CHARS = csp_pkg::MAX_BASE_CHARS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  csp_pkg::t_char    i_char,
    input  wire               i_last,
    output csp_pkg::t_result  o_result
);
    import csp_pkg::*;

    localparam int CW = $clog2(MAX_BASE_CHARS + 1);

    // Only the first BASE_LIMIT characters can ever reach the result.
    t_char        r_chars [BASE_LIMIT];
    logic [CW-1:0] r_count,  n_count;
    logic          r_sep,    n_sep;
    logic [1:0]    r_scnt,   n_scnt;
    logic [6:0]    r_sval,   n_sval;
    logic [3:0]    r_run,    n_run;
    logic [6:0]    r_tval,   n_tval;
    logic          r_rej,    n_rej;

    logic          w_digit;
    logic          w_alnum;
    t_char         w_uc;
    logic          w_wr;
    logic [CW-1:0] w_rest;
    t_result       w_res;
    logic          w_ok;
    logic [2:0]    w_blen;

    always_comb begin
        w_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        w_uc    = i_char;
        if ((i_char >= CH_LOWA) && (i_char <= CH_LOWZ)) begin
            w_uc = i_char - 8'(CASE_OFFSET);
        end
        w_alnum = ((w_uc >= CH_UPA) && (w_uc <= CH_UPZ)) || w_digit;

        n_count = r_count;
        n_sep   = r_sep;
        n_scnt  = r_scnt;
        n_sval  = r_sval;
        n_run   = r_run;
        n_tval  = r_tval;
        n_rej   = r_rej;
        w_wr    = 1'b0;

        if (!r_rej) begin
            if (r_sep) begin
                if (!w_digit) begin
                    n_rej = 1'b1;
                end else begin
                    n_sval = sat_decimal(r_sval, i_char[3:0]);
                    if (r_scnt != 2'd3) begin
                        n_scnt = r_scnt + 2'd1;
                    end
                end
            end else if ((i_char == CH_DASH) || (i_char == CH_UNDER)) begin
                n_sep = 1'b1;
            end else if (!w_alnum) begin
                n_rej = 1'b1;
            end else if (r_count >= CW'(MAX_BASE_CHARS)) begin
                n_rej = 1'b1;
            end else begin
                w_wr    = 1'b1;
                n_count = r_count + CW'(1);
                if (w_digit) begin
                    if (r_run != 4'd15) begin
                        n_run = r_run + 4'd1;
                    end
                    n_tval = sat_decimal(r_tval, i_char[3:0]);
                end else begin
                    n_run  = '0;
                    n_tval = '0;
                end
            end
        end
    end

    // Result from the state as it stands after the current character.
    always_comb begin
        w_ok    = 1'b0;
        w_blen  = '0;
        w_res   = '0;
        w_rest  = n_count - CW'(n_run);
        if (!n_rej) begin
            if (n_sep) begin
                if ((n_count >= CW'(1)) && (n_count <= CW'(BASE_LIMIT)) &&
                    (n_scnt >= 2'd1) && (n_scnt <= 2'(SSID_DIGITS)) &&
                    (n_sval <= 7'(SSID_LIMIT))) begin
                    w_ok               = 1'b1;
                    w_blen             = 3'(n_count);
                    w_res.ssid_present = 1'b1;
                    w_res.ssid_value   = n_sval[3:0];
                end
            end else if (n_count <= CW'(BASE_LIMIT)) begin
                if (n_count != '0) begin
                    w_ok   = 1'b1;
                    w_blen = 3'(n_count);
                end
            end else if ((n_run >= 4'd1) && (n_run <= 4'(SSID_DIGITS)) &&
                         (w_rest <= CW'(BASE_LIMIT)) && (w_rest >= CW'(1)) &&
                         (n_tval <= 7'(SSID_LIMIT))) begin
                w_ok               = 1'b1;
                w_blen             = 3'(w_rest);
                w_res.ssid_present = 1'b1;
                w_res.ssid_value   = n_tval[3:0];
            end
        end
        w_res.valid_res   = w_ok;
        w_res.base_length = w_blen;
        for (int i = 0; i < BASE_LIMIT; i++) begin
            if (w_ok && (3'(i) < w_blen)) begin
                if (w_wr && (r_count == CW'(i))) begin
                    w_res.base_call[CALL_W-1-8*i -: 8] = w_uc;
                end else begin
                    w_res.base_call[CALL_W-1-8*i -: 8] = r_chars[i];
                end
            end
        end
    end

    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (i_en && w_wr && (r_count < CW'(BASE_LIMIT))) begin
            r_chars[r_count[2:0]] <= w_uc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_count <= '0;
            r_sep   <= 1'b0;
            r_scnt  <= '0;
            r_sval  <= '0;
            r_run   <= '0;
            r_tval  <= '0;
            r_rej   <= 1'b0;
        end else if (i_en) begin
            r_count <= n_count;
            r_sep   <= n_sep;
            r_scnt  <= n_scnt;
            r_sval  <= n_sval;
            r_run   <= n_run;
            r_tval  <= n_tval;
            r_rej   <= n_rej;
        end
    end

endmodule

`default_nettype wire

// ===== sv/callsign_ssid_parser.sv =====
// A result is offered once the final character has passed the input register and the result register.
// Throughput: one character per cycle; a character that is not final never waits in the input register.
// The final character waits in the input register only while the result register is still full.
// Each character passes the input register and updates the parse state; a final one loads the result.
// Reset (synchronous, active low) empties both registers and clears the parse state.
`timescale 1ns / 1ps
`default_nettype none

module callsign_ssid_parser #(
    parameter int MAX_BASE_CHARS = csp_pkg::MAX_BASE_CHARS_DEF
) (
    input wire        i_clk,
    input wire        i_rst_n,
    csp_in_if.sink    i_in,
    csp_out_if.source o_out
);
    import csp_pkg::*;

    logic    r_in_valid;
    t_char   r_in_char;
    logic    r_in_last;
    logic    r_out_valid;
    t_result r_out;

    logic    w_out_free;
    logic    w_go;
    logic    w_accept;
    t_result w_result;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_go       = r_in_valid && (!r_in_last || w_out_free);
    assign i_in.ready = !r_in_valid || w_go;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_in.character;
            r_in_last <= i_in.last;
        end
    end

    csp_state #(
        .MAX_BASE_CHARS (MAX_BASE_CHARS)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_go),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.valid_res    = r_out.valid_res;
    assign o_out.base_call    = r_out.base_call;
    assign o_out.base_length  = r_out.base_length;
    assign o_out.ssid_present = r_out.ssid_present;
    assign o_out.ssid_value   = r_out.ssid_value;

    // A new result only follows a final character leaving the input register.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_go && r_in_last))
        else $error("result transaction without a final character");

    // The final character is never consumed while a result is still pending.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(w_go && r_in_last))
        else $error("pending result overwritten");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |->
        (o_out.base_call == '0 && o_out.base_length == 3'd0 &&
         !o_out.ssid_present && o_out.ssid_value == 4'd0))
        else $error("rejected callsign carries non-zero fields");

    a_valid_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.valid_res) |->
        (o_out.base_length != 3'd0 && o_out.base_length <= 3'(BASE_LIMIT)))
        else $error("accepted callsign with bad base length");

    a_ssid_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ssid_present) |-> (o_out.ssid_value == 4'd0))
        else $error("SSID value without SSID");

endmodule

`default_nettype wire
